// ----- hdl/lfia_pkg.sv -----
// lfia_pkg: word types, request kind codes and bitmap word constants for the
// lowest free identifier allocator
// no dependencies
package lfia_pkg;

    localparam int WORD_BITS = 32;
    localparam int OFF_BITS  = 5;
    localparam logic [WORD_BITS-1:0] FULL_WORD = 32'hFFFF_FFFF;

    localparam logic [1:0] KIND_ALLOC = 2'd0;
    localparam logic [1:0] KIND_REG   = 2'd1;
    localparam logic [1:0] KIND_FREE  = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [9:0] ident;
    } t_in_word;

    typedef struct packed {
        logic [9:0] granted_ident;
        logic       status;
    } t_out_word;

endpackage

// ----- hdl/lfia_word_scan.sv -----
// lfia_word_scan: masks one bitmap word and finds its lowest free bit
// depends on lfia_pkg
module lfia_word_scan
    import lfia_pkg::*;
(
    input  logic [WORD_BITS-1:0] i_word,
    input  logic [OFF_BITS-1:0]  i_off,
    input  logic                 i_first,
    input  logic                 i_last,
    input  logic [WORD_BITS-1:0] i_lim_mask,
    output logic                 o_found,
    output logic [OFF_BITS-1:0]  o_pos
);

    logic [WORD_BITS-1:0] avail;

    always_comb begin
        avail = ~i_word;
        if (i_first) begin
            avail = avail & (FULL_WORD << i_off);
        end
        if (i_last) begin
            avail = avail & i_lim_mask;
        end
        o_found = |avail;
        o_pos   = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (avail[i]) begin
                o_pos = OFF_BITS'(i);
            end
        end
    end

endmodule

// ----- hdl/lowest_free_id_allocator.sv -----
// lowest_free_id_allocator: bitmap identifier allocator, sequencer and bitmap memory
// depends on lfia_pkg and lfia_word_scan
//
//  channel | signals                                   | word
//  in      | i_in_valid, o_in_ready, i_in_word         | t_in_word  (kind, ident)
//  out     | o_out_valid, i_out_ready, o_out_word      | t_out_word (granted_ident, status)
//
// register, free and unused kinds go from accept through ST_FIN to the result
// allocate scans words upward from the hint word to the last word, at most MAP_WORDS
// one bitmap word is read and tested per cycle through the single word scan unit, while the out channel is free
// after reset a clearing pass writes MAP_WORDS words, one per cycle, before o_in_ready
// a result that is not taken holds the sequencer in ST_SCAN or ST_FIN
module lowest_free_id_allocator
    import lfia_pkg::*;
#(
    parameter int NUM_IDS = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    localparam int MAP_WORDS = (NUM_IDS + WORD_BITS - 1) / WORD_BITS;
    localparam int WW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int HW        = $clog2(NUM_IDS + 1);
    localparam int XW        = (HW > 10) ? HW : 10;
    localparam int LAST_BITS = NUM_IDS - WORD_BITS * (MAP_WORDS - 1);
    localparam logic [WORD_BITS-1:0] LIM_MASK =
        WORD_BITS'((33'd1 << LAST_BITS) - 33'd1);
    localparam logic [WW-1:0] LAST_WORD = WW'(MAP_WORDS - 1);

    localparam logic [1:0] ST_CLR  = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [WORD_BITS-1:0] mem [MAP_WORDS];

    logic [1:0]           r_state, n_state;
    logic [WW-1:0]        r_word, n_word;
    logic                 r_first, n_first;
    logic [1:0]           r_kind, n_kind;
    logic [XW-1:0]        r_ident, n_ident;
    logic [OFF_BITS-1:0]  r_bit, n_bit;
    logic                 r_wr_en, n_wr_en;
    logic                 r_status, n_status;
    logic [HW-1:0]        r_hint, n_hint;
    logic                 r_ovalid, n_ovalid;
    t_out_word            r_odata, n_odata;
    logic [WORD_BITS-1:0] r_rdata;

    logic                 mem_we;
    logic [WW-1:0]        mem_waddr, mem_raddr;
    logic [WORD_BITS-1:0] mem_wdata;

    logic                 out_free, accept;
    logic [XW-1:0]        ident_x;
    logic                 in_range;
    logic [WW-1:0]        hint_word, ident_word;
    logic                 scan_found;
    logic [OFF_BITS-1:0]  scan_pos;
    logic [HW-1:0]        found_id;

    lfia_word_scan u_scan (
        .i_word     (r_rdata),
        .i_off      (r_hint[OFF_BITS-1:0]),
        .i_first    (r_first),
        .i_last     (r_word == LAST_WORD),
        .i_lim_mask (LIM_MASK),
        .o_found    (scan_found),
        .o_pos      (scan_pos)
    );

    assign out_free   = !r_ovalid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign ident_x    = XW'(i_in_word.ident);
    assign in_range   = ident_x < XW'(NUM_IDS);
    assign hint_word  = WW'(r_hint >> OFF_BITS);
    assign ident_word = WW'(ident_x >> OFF_BITS);
    assign found_id   = HW'({r_word, scan_pos});

    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_odata;

    always_comb begin
        n_state   = r_state;
        n_word    = r_word;
        n_first   = r_first;
        n_kind    = r_kind;
        n_ident   = r_ident;
        n_bit     = r_bit;
        n_wr_en   = r_wr_en;
        n_status  = r_status;
        n_hint    = r_hint;
        n_ovalid  = r_ovalid && !i_out_ready;
        n_odata   = r_odata;
        mem_we    = 1'b0;
        mem_waddr = r_word;
        mem_raddr = r_word;
        mem_wdata = '0;
        unique case (r_state)
            ST_CLR: begin
                mem_we = 1'b1;
                if (r_word == LAST_WORD) begin
                    n_word  = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_word = r_word + 1'b1;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_kind = i_in_word.kind;
                    if (i_in_word.kind == KIND_ALLOC) begin
                        if (r_hint >= HW'(NUM_IDS)) begin
                            n_status = 1'b1;
                            n_wr_en  = 1'b0;
                            n_state  = ST_FIN;
                        end else begin
                            n_word    = hint_word;
                            mem_raddr = hint_word;
                            n_first   = 1'b1;
                            n_state   = ST_SCAN;
                        end
                    end else begin
                        n_word    = ident_word;
                        mem_raddr = ident_word;
                        n_ident   = ident_x;
                        n_bit     = i_in_word.ident[OFF_BITS-1:0];
                        n_wr_en   = in_range && (i_in_word.kind == KIND_REG ||
                                                 i_in_word.kind == KIND_FREE);
                        n_status  = 1'b0;
                        n_state   = ST_FIN;
                    end
                end
            end
            ST_SCAN: begin
                if (out_free) begin
                    if (scan_found) begin
                        mem_we    = 1'b1;
                        mem_wdata = r_rdata | (32'd1 << scan_pos);
                        n_hint    = found_id + 1'b1;
                        n_odata.granted_ident = 10'(found_id);
                        n_odata.status        = 1'b0;
                        n_ovalid  = 1'b1;
                        n_state   = ST_IDLE;
                    end else if (r_word == LAST_WORD) begin
                        n_odata.granted_ident = '0;
                        n_odata.status        = 1'b1;
                        n_ovalid  = 1'b1;
                        n_state   = ST_IDLE;
                    end else begin
                        n_word    = r_word + 1'b1;
                        mem_raddr = r_word + 1'b1;
                        n_first   = 1'b0;
                    end
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    if (r_wr_en) begin
                        mem_we = 1'b1;
                        if (r_kind == KIND_REG) begin
                            mem_wdata = r_rdata | (32'd1 << r_bit);
                        end else begin
                            mem_wdata = r_rdata & ~(32'd1 << r_bit);
                        end
                        if (r_kind == KIND_FREE && r_ident < XW'(r_hint)) begin
                            n_hint = HW'(r_ident);
                        end
                    end
                    n_odata.granted_ident = '0;
                    n_odata.status        = r_status;
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLR;
            r_word   <= '0;
            r_first  <= 1'b0;
            r_kind   <= KIND_ALLOC;
            r_wr_en  <= 1'b0;
            r_status <= 1'b0;
            r_hint   <= HW'(1);
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_word   <= n_word;
            r_first  <= n_first;
            r_kind   <= n_kind;
            r_wr_en  <= n_wr_en;
            r_status <= n_status;
            r_hint   <= n_hint;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ident <= n_ident;
        r_bit   <= n_bit;
        r_odata <= n_odata;
    end

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !mem_we)
        else $error("bitmap written while idle");

    a_hint_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hint <= HW'(NUM_IDS))
        else $error("hint beyond identifier range");

    a_scan_from_hint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_word >= hint_word))
        else $error("scan below hint word");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_SCAN || r_state == ST_FIN))
        else $error("accepted word did not start the sequencer");

endmodule
